// ===== rtl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for rational_add_reduce
// Item layouts, working widths and the divider request/response bundles.
// ----------------------------------------------------------------------------
package rar_pkg;

	localparam int IN_WIDTH  = 16;
	// products, sums and the gcd all live in this width
	localparam int PROD_W    = 2 * IN_WIDTH;
	localparam int CNT_W     = $clog2(PROD_W);
	localparam int MAG_OUT_W = 32;
	localparam int DEN_OUT_W = 31;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] a_numerator;
		logic signed [IN_WIDTH-1:0] a_denominator;
		logic signed [IN_WIDTH-1:0] b_numerator;
		logic signed [IN_WIDTH-1:0] b_denominator;
	} in_item_t;

	typedef struct packed {
		logic                 sum_negative;
		logic [MAG_OUT_W-1:0] sum_magnitude;
		logic [DEN_OUT_W-1:0] sum_denominator;
		logic                 zero_denominator;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [PROD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/rar_div.sv =====
// ----------------------------------------------------------------------------
// rar_div: iterative restoring divider
// One quotient bit per cycle; done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
module rar_div (
	input  logic             clk,
	input  logic             arst_n,
	input  rar_pkg::div_req_t req,
	output rar_pkg::div_rsp_t rsp
);
	import rar_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] quo_q;
	logic [PROD_W-1:0] dvs_q;
	logic [PROD_W:0]   rem_q;
	logic [PROD_W:0]   rem_sh;
	logic [PROD_W:0]   diff;
	logic              fit;

	assign rem_sh = {rem_q[PROD_W-1:0], quo_q[PROD_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign fit    = !diff[PROD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	// dividend shifts out of the top of quo_q while quotient bits enter below
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? diff : rem_sh;
			quo_q <= {quo_q[PROD_W-2:0], fit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(busy_q) && busy_q |-> rem_q < {1'b0, dvs_q})
		else $error("partial remainder not below divisor");

endmodule

// ===== rtl/rational_add_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_add_reduce: signed fraction adder with gcd reduction
// Cross-multiplies two fractions, then reduces the sum by its gcd.
// ----------------------------------------------------------------------------
//  channel | signals                      | item
//  --------+------------------------------+----------------------------------
//  in      | in_valid, in_stall, in_data  | two fractions, num/den each
//  out     | out_valid, out_stall, out_data | reduced sign, num, den, error
//
// One item at a time. Accept, three products on one multiplier, combine,
// binary gcd (one subtract-or-shift per cycle), then two restoring divisions,
// magnitude then denominator. A zero sum skips the gcd and the divisions; a
// zero denominator goes straight from accept to the result.
// in_stall is high from accept until the result is loaded into the output
// register; a stalled output only holds the block in its final state.
// Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_add_reduce (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rar_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rar_pkg::out_item_t out_data
);
	import rar_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MUL     = 7'b0000010,
		ST_SUM     = 7'b0000100,
		ST_GCD     = 7'b0001000,
		ST_DIV_MAG = 7'b0010000,
		ST_DIV_DEN = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	function automatic logic [IN_WIDTH-1:0] mag_of(input logic [IN_WIDTH-1:0] v);
		logic [IN_WIDTH-1:0] r;
		r = v[IN_WIDTH-1] ? (~v + IN_WIDTH'(1)) : v;
		return r;
	endfunction

	state_t            state_q;
	logic [1:0]        mstep_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [IN_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic              sa_q, sb_q;
	logic [PROD_W-1:0] t1_q, t2_q, den_q, mag_q, x_q, y_q, g_q;
	logic [CNT_W-1:0]  k_q;
	logic              neg_q, zden_q;

	logic [IN_WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
	logic              in_zden;
	logic              accept;

	logic [IN_WIDTH-1:0] mul_a, mul_b;
	logic [PROD_W-1:0] prod;

	logic              same_sign, t1_ge;
	logic [PROD_W-1:0] sum_mag;
	logic              sum_neg;

	logic              x_even, y_even, x_gt, gcd_fin;
	logic [PROD_W-1:0] gdiff, gcd_now;

	logic              out_load;
	logic [63:0]       mag64, den64;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign in_an   = mag_of(in_data.a_numerator);
	assign in_ad   = mag_of(in_data.a_denominator);
	assign in_bn   = mag_of(in_data.b_numerator);
	assign in_bd   = mag_of(in_data.b_denominator);
	assign in_zden = (in_ad == '0) || (in_bd == '0);

	// shared multiplier: a_num*b_den, b_num*a_den, a_den*b_den
	always_comb begin
		case (mstep_q)
			2'd0:    begin mul_a = an_q; mul_b = bd_q; end
			2'd1:    begin mul_a = bn_q; mul_b = ad_q; end
			default: begin mul_a = ad_q; mul_b = bd_q; end
		endcase
	end
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign same_sign = (sa_q == sb_q);
	assign t1_ge     = (t1_q >= t2_q);
	always_comb begin
		if (same_sign) begin
			sum_mag = t1_q + t2_q;
			sum_neg = sa_q;
		end else if (t1_ge) begin
			sum_mag = t1_q - t2_q;
			sum_neg = sa_q;
		end else begin
			sum_mag = t2_q - t1_q;
			sum_neg = sb_q;
		end
	end

	// binary gcd step
	assign x_even  = !x_q[0];
	assign y_even  = !y_q[0];
	assign x_gt    = (x_q > y_q);
	assign gdiff   = x_gt ? (x_q - y_q) : (y_q - x_q);
	assign gcd_fin = !x_even && !y_even && (x_q == y_q);
	assign gcd_now = x_q << k_q;

	assign div_req.start    = ((state_q == ST_GCD) && gcd_fin) ||
	                          ((state_q == ST_DIV_MAG) && div_rsp.done);
	assign div_req.dividend = (state_q == ST_GCD) ? mag_q : den_q;
	assign div_req.divisor  = (state_q == ST_GCD) ? gcd_now : g_q;

	rar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mstep_q <= '0;
						state_q <= in_zden ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd2)
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= (sum_mag == '0) ? ST_DONE : ST_GCD;
				end
				ST_GCD: begin
					if (gcd_fin)
						state_q <= ST_DIV_MAG;
				end
				ST_DIV_MAG: begin
					if (div_rsp.done)
						state_q <= ST_DIV_DEN;
				end
				ST_DIV_DEN: begin
					if (div_rsp.done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					an_q   <= in_an;
					ad_q   <= in_ad;
					bn_q   <= in_bn;
					bd_q   <= in_bd;
					sa_q   <= in_data.a_numerator[IN_WIDTH-1] ^ in_data.a_denominator[IN_WIDTH-1];
					sb_q   <= in_data.b_numerator[IN_WIDTH-1] ^ in_data.b_denominator[IN_WIDTH-1];
					neg_q  <= 1'b0;
					mag_q  <= '0;
					den_q  <= '0;
					zden_q <= in_zden;
				end
			end
			ST_MUL: begin
				case (mstep_q)
					2'd0:    t1_q  <= prod;
					2'd1:    t2_q  <= prod;
					default: den_q <= prod;
				endcase
			end
			ST_SUM: begin
				if (sum_mag == '0) begin
					// zero sum reads as +0/1
					neg_q <= 1'b0;
					mag_q <= '0;
					den_q <= PROD_W'(1);
				end else begin
					neg_q <= sum_neg;
					mag_q <= sum_mag;
					x_q   <= sum_mag;
					y_q   <= den_q;
					k_q   <= '0;
				end
			end
			ST_GCD: begin
				if (x_even && y_even) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (x_even) begin
					x_q <= x_q >> 1;
				end else if (y_even) begin
					y_q <= y_q >> 1;
				end else if (gcd_fin) begin
					g_q <= gcd_now;
				end else if (x_gt) begin
					x_q <= gdiff >> 1;
				end else begin
					y_q <= gdiff >> 1;
				end
			end
			ST_DIV_MAG: begin
				if (div_rsp.done)
					mag_q <= div_rsp.quotient;
			end
			ST_DIV_DEN: begin
				if (div_rsp.done)
					den_q <= div_rsp.quotient;
			end
			default: begin
			end
		endcase
	end

	assign mag64 = 64'(mag_q);
	assign den64 = 64'(den_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sum_negative     <= neg_q;
			out_q.sum_magnitude    <= mag64[MAG_OUT_W-1:0];
			out_q.sum_denominator  <= den64[DEN_OUT_W-1:0];
			out_q.zero_denominator <= zden_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_zden_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_denominator |->
			!out_data.sum_negative && (out_data.sum_magnitude == '0) &&
			(out_data.sum_denominator == '0))
		else $error("error item carries nonzero fields");

	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.zero_denominator && (out_data.sum_magnitude == '0) |->
			!out_data.sum_negative && (out_data.sum_denominator == DEN_OUT_W'(1)))
		else $error("zero sum not reported as +0/1");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD) |-> (x_q != '0) && (y_q != '0))
		else $error("gcd operand reached zero");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_MAG) || (state_q == ST_DIV_DEN))
		else $error("divider finished outside a divide state");

endmodule
